/* src/cps_pkg.sv */
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants for the closest point on segment block
// Holds the coordinate, difference and accumulator widths and the result mode.
// ----------------------------------------------------------------------------
`default_nettype none
package cps_pkg;
  localparam int COORD_BITS = 32;
  localparam int RATIO_BITS = 24;
  localparam int DIF_W      = COORD_BITS + 1;
  localparam int PRD_W      = 2 * DIF_W;
  localparam int ACC_W      = PRD_W + 2;
  localparam int REM_W      = ACC_W + 1;
  localparam int OFS_W      = DIF_W + RATIO_BITS + 1;
  // stage map: diff, products, sums, classify, divide steps, scale, output
  localparam int ST_DIV0    = 4;
  localparam int ST_MUL     = ST_DIV0 + RATIO_BITS;
  localparam int STAGES     = ST_MUL + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIF_W-1:0]      dif_t;
  typedef logic signed [PRD_W-1:0]      prd_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic        [REM_W-1:0]      rem_t;
  typedef logic        [RATIO_BITS-1:0] ratio_t;
  typedef logic signed [OFS_W-1:0]      ofs_t;

  typedef enum logic [1:0] {
    MODE_START,
    MODE_END,
    MODE_INTERP
  } mode_t;
endpackage
`default_nettype wire

/* src/cps_if.sv */
// ----------------------------------------------------------------------------
// cps_in_if / cps_out_if: valid/ready channels of the closest point block
// Input carries segment start, end and query point; output the nearest point.
// ----------------------------------------------------------------------------
`default_nettype none
interface cps_in_if;
  logic valid;
  logic ready;
  cps_pkg::coord_t start_x, start_y, start_z;
  cps_pkg::coord_t end_x, end_y, end_z;
  cps_pkg::coord_t query_x, query_y, query_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  query_x, query_y, query_z, input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  query_x, query_y, query_z, output ready);
endinterface

interface cps_out_if;
  logic valid;
  logic ready;
  cps_pkg::coord_t nearest_x, nearest_y, nearest_z;
  modport source (output valid, nearest_x, nearest_y, nearest_z, input ready);
  modport sink   (input valid, nearest_x, nearest_y, nearest_z, output ready);
endinterface
`default_nettype wire

/* src/closest_point_on_segment.sv */
// ----------------------------------------------------------------------------
// closest_point_on_segment: nearest point of a 3D segment to a query point
// Projects query - start onto end - start and clamps or interpolates.
// ----------------------------------------------------------------------------
// One item enters per cycle while in_ch.ready is high. The stages are one
// of differences, one of 33x33 products, one of sums, one of classification,
// 24 restoring divide steps (one ratio bit each), one scaling multiply and the
// output register. Every stage has its own valid bit and moves on when the
// next stage is empty or moving, so a stalled output holds back only the run of full stages before it.
`default_nettype none
module closest_point_on_segment (
  input  wire logic clk,
  input  wire logic rst_n,
  cps_in_if.sink    in_ch,
  cps_out_if.source out_ch
);
  import cps_pkg::*;

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] en;

  dif_t   s_r    [ST_MUL+1][3];
  dif_t   d_r    [ST_MUL+1][3];
  dif_t   w_r    [3];
  prd_t   pdv_r  [3];
  prd_t   pdd_r  [3];
  acc_t   dot_r, len2_r;
  mode_t  mode_r [ST_DIV0-1:ST_MUL];
  rem_t   rem_r  [ST_DIV0-1:ST_MUL-1];
  acc_t   lenq_r [ST_DIV0-1:ST_MUL-1];
  ratio_t t_r    [ST_DIV0-1:ST_MUL-1];
  ofs_t   ofs_r  [3];
  coord_t near_r [3];

  coord_t in_s [3];
  coord_t in_e [3];
  coord_t in_q [3];

  assign in_s = '{in_ch.start_x, in_ch.start_y, in_ch.start_z};
  assign in_e = '{in_ch.end_x, in_ch.end_y, in_ch.end_z};
  assign in_q = '{in_ch.query_x, in_ch.query_y, in_ch.query_z};

  // a stage advances when the one after it is empty or advancing
  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || out_ch.ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // differences
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        s_r[0][i] <= DIF_W'(in_s[i]);
        d_r[0][i] <= DIF_W'(in_e[i]) - DIF_W'(in_s[i]);
        w_r[i]    <= DIF_W'(in_q[i]) - DIF_W'(in_s[i]);
      end
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        s_r[1][i] <= s_r[0][i];
        d_r[1][i] <= d_r[0][i];
        pdv_r[i]  <= PRD_W'(d_r[0][i] * w_r[i]);
        pdd_r[i]  <= PRD_W'(d_r[0][i] * d_r[0][i]);
      end
    end
  end

  // sums
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s_r[2]  <= s_r[1];
      d_r[2]  <= d_r[1];
      dot_r   <= ACC_W'(pdv_r[0]) + ACC_W'(pdv_r[1]) + ACC_W'(pdv_r[2]);
      len2_r  <= ACC_W'(pdd_r[0]) + ACC_W'(pdd_r[1]) + ACC_W'(pdd_r[2]);
    end
  end

  // classify: at or before start, at or beyond end, or in between
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s_r[3] <= s_r[2];
      d_r[3] <= d_r[2];
      if (dot_r[ACC_W-1] || dot_r == '0) begin
        mode_r[3] <= MODE_START;
      end else if (dot_r >= len2_r) begin
        mode_r[3] <= MODE_END;
      end else begin
        mode_r[3] <= MODE_INTERP;
      end
      rem_r[3]  <= REM_W'(unsigned'(dot_r));
      lenq_r[3] <= len2_r;
      t_r[3]    <= '0;
    end
  end

  // restoring divide, one ratio bit per stage
  for (genvar j = ST_DIV0; j < ST_MUL; j++) begin : g_div
    rem_t sh;
    logic ge;
    assign sh = {rem_r[j-1][REM_W-2:0], 1'b0};
    assign ge = sh >= REM_W'(unsigned'(lenq_r[j-1]));
    always_ff @(posedge clk) begin
      if (en[j]) begin
        s_r[j]    <= s_r[j-1];
        d_r[j]    <= d_r[j-1];
        mode_r[j] <= mode_r[j-1];
        lenq_r[j] <= lenq_r[j-1];
        rem_r[j]  <= ge ? sh - REM_W'(unsigned'(lenq_r[j-1])) : sh;
        t_r[j]    <= {t_r[j-1][RATIO_BITS-2:0], ge};
      end
    end
  end

  // scale direction by the ratio
  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      s_r[ST_MUL]    <= s_r[ST_MUL-1];
      d_r[ST_MUL]    <= d_r[ST_MUL-1];
      mode_r[ST_MUL] <= mode_r[ST_MUL-1];
      for (int i = 0; i < 3; i++) begin
        ofs_r[i] <= OFS_W'(d_r[ST_MUL-1][i] * signed'({1'b0, t_r[ST_MUL-1]}));
      end
    end
  end

  // round half up, add to start, pick the result
  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      for (int i = 0; i < 3; i++) begin
        case (mode_r[ST_MUL])
          MODE_START: near_r[i] <= s_r[ST_MUL][i][COORD_BITS-1:0];
          MODE_END:   near_r[i] <= COORD_BITS'(s_r[ST_MUL][i] + d_r[ST_MUL][i]);
          default:    near_r[i] <= s_r[ST_MUL][i][COORD_BITS-1:0]
                         + COORD_BITS'((ofs_r[i] + (OFS_W'(1) <<< (RATIO_BITS - 1)))
                                       >>> RATIO_BITS);
        endcase
      end
    end
  end

  assign out_ch.valid     = vld_r[STAGES-1];
  assign out_ch.nearest_x = near_r[0];
  assign out_ch.nearest_y = near_r[1];
  assign out_ch.nearest_z = near_r[2];

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
  a_empty_head_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_ch.ready)
    else $error("input stalled with empty first stage");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.nearest_x))
    else $error("stalled result lost");
endmodule
`default_nettype wire
